// ===== design/battery_gauge_smoother_macros.svh =====
// Assertion macros for the battery gauge smoother.
// Used by the top level; expects signals clock and reset in scope.
`ifndef BATTERY_GAUGE_SMOOTHER_MACROS_SVH
`define BATTERY_GAUGE_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BGS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("battery gauge smoother: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BGS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("battery gauge smoother: next-cycle check failed");

`endif

// ===== design/bgs_pkg.sv =====
// Shared constants and types of the battery gauge smoother.
// No dependencies; imported by the interfaces and all modules.
package bgs_pkg;

   localparam int ADC_BITS = 12;
   localparam int MV_W     = 14;
   localparam int PCT_W    = 8;
   localparam int PQ8_W    = 16;
   localparam int ALPHA_W  = 9;
   localparam int OPD_W    = 16;
   localparam int MAC_W    = 32;
   localparam int DVD_W    = 29;
   localparam int DVS_W    = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MV_MIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MV_MAX   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MV_SPAN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_Q8 = 2'd3;

   localparam logic [MV_W-1:0]    MV_MIN_RST   = 14'd3300;
   localparam logic [MV_W-1:0]    MV_MAX_RST   = 14'd4200;
   localparam logic [MV_W-1:0]    MV_SPAN_RST  = 14'd900;
   localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd20;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;

   localparam int MV_SCALE         = 14748;
   localparam int MV_EMA_KEEP      = 15;
   localparam int MV_EMA_RND       = 8;
   localparam logic [MV_W-1:0] MV_VALID_MIN = 14'd2500;
   localparam int PCT_FULL_Q8      = 25600;
   localparam int PCT_HALF_Q8      = 128;
   localparam logic [PCT_W-1:0] PCT_INVALID = 8'hFF;
   localparam logic [PCT_W:0]   PCT_CAP     = 9'd100;

   typedef struct packed {
      logic             en;
      logic             clr;
      logic [MAC_W-1:0] c;
      logic [OPD_W-1:0] a;
      logic [OPD_W-1:0] b;
   } bgs_mac_cmd_type;

endpackage

// ===== design/bgs_req_if.sv =====
// Input channel of the battery gauge smoother: valid/ready plus sample beat.
// Depends on bgs_pkg.
interface bgs_req_if;
   import bgs_pkg::*;
   logic                valid;
   logic                ready;
   logic                command;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output command, output adc_sample, input ready);
   modport sink   (input valid, input command, input adc_sample, output ready);
endinterface

// ===== design/bgs_rsp_if.sv =====
// Result channel of the battery gauge smoother: valid/ready plus result beat.
// Depends on bgs_pkg.
interface bgs_rsp_if;
   import bgs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic        [MV_W-1:0]  battery_mv;
   logic signed [PCT_W-1:0] percent;

   modport source (output valid, output battery_mv, output percent, input ready);
   modport sink   (input valid, input battery_mv, input percent, output ready);
endinterface

// ===== design/bgs_mac.sv =====
// Shared multiply-accumulate unit: acc <= (clr ? c : acc) + a * b while en is high.
// Depends on bgs_pkg.
module bgs_mac (
   input  logic                     clock,
   input  bgs_pkg::bgs_mac_cmd_type cmd,
   output logic [bgs_pkg::MAC_W-1:0] acc
);
   import bgs_pkg::*;

   logic [MAC_W-1:0] acc_ff, acc_in;
   logic [MAC_W-1:0] prod;

   assign prod   = cmd.a * cmd.b;
   assign acc_in = (cmd.clr ? cmd.c : acc_ff) + prod;

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule

// ===== design/bgs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bgs_pkg.
module bgs_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bgs_pkg::DVD_W-1:0] dividend,
   input  logic [bgs_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [bgs_pkg::DVD_W-1:0] quotient
);
   import bgs_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_diff;
   logic             fits;

   assign rem_sh   = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign fits     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff : rem_sh;
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== design/battery_gauge_smoother.sv =====
// Battery gauge smoother: one 12-bit sample beat in, one result beat out
// (smoothed millivolts, and smoothed percent or -1). A small sequencer steps each
// sample through one shared multiply-accumulate unit and a bit-serial divider, the
// latter only when the linear map divides by the span. The input is not ready while a
// sample is in work; a finished result waits in the output register while the next
// sample is taken.
// Configuration: csr_we, csr_index (0 min, 1 max, 2 span, 3 alpha), csr_wdata;
// write only while idle. Depends on bgs_pkg, the channel interfaces, bgs_mac,
// bgs_divider and battery_gauge_smoother_macros.svh.
`include "battery_gauge_smoother_macros.svh"

module battery_gauge_smoother (
   input  logic                          clock,
   input  logic                          reset,
   bgs_req_if.sink                       req_ch,
   bgs_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [bgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bgs_pkg::MV_W-1:0]      csr_wdata
);
   import bgs_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCALE    = 4'd1;
   localparam logic [3:0] ST_MV       = 4'd2;
   localparam logic [3:0] ST_MV_AVG   = 4'd3;
   localparam logic [3:0] ST_PCT      = 4'd4;
   localparam logic [3:0] ST_NUM      = 4'd5;
   localparam logic [3:0] ST_DIV_GO   = 4'd6;
   localparam logic [3:0] ST_DIV_WAIT = 4'd7;
   localparam logic [3:0] ST_EMA      = 4'd8;
   localparam logic [3:0] ST_EMA_MIX  = 4'd9;
   localparam logic [3:0] ST_EMA_TAKE = 4'd10;
   localparam logic [3:0] ST_ROUND    = 4'd11;
   localparam logic [3:0] ST_OUT      = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [MV_W-1:0]     mv_min_ff, mv_max_ff, mv_span_ff;
   logic [ALPHA_W-1:0]  alpha_ff;
   logic                cmd_ff, cmd_in;
   logic [ADC_BITS-1:0] raw_ff, raw_in;
   logic [MV_W-1:0]     mv_avg_ff, mv_avg_in;
   logic [PQ8_W-1:0]    pct_avg_ff, pct_avg_in;
   logic                pct_seeded_ff, pct_seeded_in;
   logic [PQ8_W-1:0]    lin_ff, lin_in;
   logic [PCT_W-1:0]    pct_res_ff, pct_res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]     rsp_mv_ff;
   logic [PCT_W-1:0]    rsp_pct_ff;
   logic                rsp_load;

   bgs_mac_cmd_type     mac_cmd;
   logic [MAC_W-1:0]    mac_acc;
   logic                div_start;
   logic                div_done;
   logic [DVD_W-1:0]    div_quo;

   logic [MV_W-1:0]     inst_mv;
   logic [ALPHA_W-1:0]  alpha_sat;
   logic [PQ8_W:0]      pct_rnd;
   logic [PCT_W:0]      pct_whole;
   logic                req_accept;

   bgs_mac u_mac (
      .clock (clock),
      .cmd   (mac_cmd),
      .acc   (mac_acc)
   );

   bgs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mac_acc[DVD_W-1:0]),
      .divisor  (mv_span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign inst_mv   = mac_acc[ADC_BITS+MV_W-1:ADC_BITS];
   assign alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign pct_rnd   = {1'b0, pct_avg_ff} + (PQ8_W+1)'(PCT_HALF_Q8);
   assign pct_whole = pct_rnd[PQ8_W:8];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      raw_in        = raw_ff;
      mv_avg_in     = mv_avg_ff;
      pct_avg_in    = pct_avg_ff;
      pct_seeded_in = pct_seeded_ff;
      lin_in        = lin_ff;
      pct_res_in    = pct_res_ff;
      rsp_load      = 1'b0;
      div_start     = 1'b0;
      mac_cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_ch.command;
               raw_in   = req_ch.adc_sample;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mac_cmd.en  = 1'b1;
            mac_cmd.clr = 1'b1;
            mac_cmd.c   = MAC_W'(1) << (ADC_BITS - 1);
            mac_cmd.a   = OPD_W'(raw_ff);
            mac_cmd.b   = OPD_W'(MV_SCALE);
            state_in    = ST_MV;
         end
         ST_MV: begin
            if (raw_ff == '0) begin
               mv_avg_in = '0;
               state_in  = ST_PCT;
            end else if (mv_avg_ff == '0) begin
               mv_avg_in = inst_mv;
               state_in  = ST_PCT;
            end else begin
               mac_cmd.en  = 1'b1;
               mac_cmd.clr = 1'b1;
               mac_cmd.c   = MAC_W'(inst_mv) + MAC_W'(MV_EMA_RND);
               mac_cmd.a   = OPD_W'(MV_EMA_KEEP);
               mac_cmd.b   = OPD_W'(mv_avg_ff);
               state_in    = ST_MV_AVG;
            end
         end
         ST_MV_AVG: begin
            mv_avg_in = mac_acc[MV_W+3:4];
            state_in  = ST_PCT;
         end
         ST_PCT: begin
            if (!cmd_ff) begin
               pct_res_in = PCT_INVALID;
               state_in   = ST_OUT;
            end else if (mv_avg_ff < MV_VALID_MIN) begin
               pct_seeded_in = 1'b0;
               pct_avg_in    = '0;
               pct_res_in    = PCT_INVALID;
               state_in      = ST_OUT;
            end else if (mv_avg_ff >= mv_max_ff) begin
               lin_in   = PQ8_W'(PCT_FULL_Q8);
               state_in = ST_EMA;
            end else if (mv_avg_ff <= mv_min_ff) begin
               lin_in   = '0;
               state_in = ST_EMA;
            end else if (mv_span_ff == '0) begin
               lin_in   = PQ8_W'(PCT_FULL_Q8);
               state_in = ST_EMA;
            end else begin
               mac_cmd.en  = 1'b1;
               mac_cmd.clr = 1'b1;
               mac_cmd.c   = '0;
               mac_cmd.a   = OPD_W'(mv_avg_ff - mv_min_ff);
               mac_cmd.b   = OPD_W'(PCT_FULL_Q8);
               state_in    = ST_NUM;
            end
         end
         ST_NUM: begin
            // add the half-step round: span * 128
            mac_cmd.en = 1'b1;
            mac_cmd.a  = OPD_W'(mv_span_ff);
            mac_cmd.b  = OPD_W'(PCT_HALF_Q8);
            state_in   = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               lin_in = (div_quo > DVD_W'(PCT_FULL_Q8)) ? PQ8_W'(PCT_FULL_Q8)
                                                        : div_quo[PQ8_W-1:0];
               state_in = ST_EMA;
            end
         end
         ST_EMA: begin
            if (!pct_seeded_ff) begin
               pct_avg_in    = lin_ff;
               pct_seeded_in = 1'b1;
               state_in      = ST_ROUND;
            end else begin
               mac_cmd.en  = 1'b1;
               mac_cmd.clr = 1'b1;
               mac_cmd.c   = MAC_W'(PCT_HALF_Q8);
               mac_cmd.a   = OPD_W'(ALPHA_ONE - alpha_sat);
               mac_cmd.b   = pct_avg_ff;
               state_in    = ST_EMA_MIX;
            end
         end
         ST_EMA_MIX: begin
            mac_cmd.en = 1'b1;
            mac_cmd.a  = OPD_W'(alpha_sat);
            mac_cmd.b  = lin_ff;
            state_in   = ST_EMA_TAKE;
         end
         ST_EMA_TAKE: begin
            pct_avg_in = mac_acc[PQ8_W+7:8];
            state_in   = ST_ROUND;
         end
         ST_ROUND: begin
            pct_res_in = (pct_whole > PCT_CAP) ? PCT_CAP[PCT_W-1:0]
                                               : pct_whole[PCT_W-1:0];
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         mv_avg_ff     <= '0;
         pct_avg_ff    <= '0;
         pct_seeded_ff <= 1'b0;
         mv_min_ff     <= MV_MIN_RST;
         mv_max_ff     <= MV_MAX_RST;
         mv_span_ff    <= MV_SPAN_RST;
         alpha_ff      <= ALPHA_RST;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         mv_avg_ff     <= mv_avg_in;
         pct_avg_ff    <= pct_avg_in;
         pct_seeded_ff <= pct_seeded_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MV_MIN:   mv_min_ff  <= csr_wdata;
               CSR_MV_MAX:   mv_max_ff  <= csr_wdata;
               CSR_MV_SPAN:  mv_span_ff <= csr_wdata;
               CSR_ALPHA_Q8: alpha_ff   <= csr_wdata[ALPHA_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      raw_ff     <= raw_in;
      lin_ff     <= lin_in;
      pct_res_ff <= pct_res_in;
      if (rsp_load) begin
         rsp_mv_ff  <= mv_avg_ff;
         rsp_pct_ff <= pct_res_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.battery_mv = rsp_mv_ff;
   assign rsp_ch.percent    = rsp_pct_ff;

   `BGS_ASSERT_NEXT(a_div_to_ema, (state_ff == ST_DIV_WAIT) && div_done, state_ff == ST_EMA)
   `BGS_ASSERT_NOW(a_unseeded_zero, !pct_seeded_ff, pct_avg_ff == '0)
   `BGS_ASSERT_NOW(a_pct_range, rsp_valid_ff && (rsp_pct_ff != PCT_INVALID), rsp_pct_ff <= 8'd100)
   `BGS_ASSERT_NEXT(a_busy_after_take, req_accept, !req_ch.ready)
endmodule

// ===== tb/tb_battery_gauge_smoother.sv =====
`timescale 1ns / 100ps
// Self-checking bench for battery_gauge_smoother: random and directed sample beats, config
// phases, and a scoreboard that predicts smoothed millivolts and percent per beat.
// Depends on bgs_pkg, bgs_req_if, bgs_rsp_if and the battery_gauge_smoother RTL.
module tb_battery_gauge_smoother;
   import bgs_pkg::*;

   localparam bit CMD_MV_ONLY = 1'b0;
   localparam bit CMD_MV_PCT  = 1'b1;
   localparam int CYCLE_LIMIT = 400000;

   class gauge_scoreboard_type;
      typedef struct {
         bit [MV_W-1:0]  mv;
         bit [PCT_W-1:0] pct;
      } reading_type;

      bit [MV_W-1:0]    mv_min;
      bit [MV_W-1:0]    mv_max;
      bit [MV_W-1:0]    mv_span;
      bit [ALPHA_W-1:0] alpha;
      bit [MV_W-1:0]    mv_avg;
      bit [PQ8_W-1:0]   pct_avg;
      bit               pct_seeded;
      reading_type      due[$];
      int               errors;

      function new();
         mv_min     = MV_MIN_RST;
         mv_max     = MV_MAX_RST;
         mv_span    = MV_SPAN_RST;
         alpha      = ALPHA_RST;
         mv_avg     = '0;
         pct_avg    = '0;
         pct_seeded = 1'b0;
         errors     = 0;
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [MV_W-1:0] val);
         case (idx)
            CSR_MV_MIN:   mv_min  = val;
            CSR_MV_MAX:   mv_max  = val;
            CSR_MV_SPAN:  mv_span = val;
            CSR_ALPHA_Q8: alpha   = val[ALPHA_W-1:0];
            default: ;
         endcase
      endfunction

      // Linear map of millivolts to percent in Q8, with half-step round.
      function bit [PQ8_W-1:0] map_pct_q8(bit [MV_W-1:0] mv);
         bit [63:0] num;
         bit [63:0] quo;
         if (mv >= mv_max) return PQ8_W'(PCT_FULL_Q8);
         if (mv <= mv_min) return '0;
         if (mv_span == '0) return PQ8_W'(PCT_FULL_Q8);
         num = (64'(mv) - 64'(mv_min)) * 64'(PCT_FULL_Q8) + 64'(mv_span) * 64'(PCT_HALF_Q8);
         quo = num / 64'(mv_span);
         if (quo > 64'(PCT_FULL_Q8)) quo = 64'(PCT_FULL_Q8);
         return quo[PQ8_W-1:0];
      endfunction

      function void note_sample(bit cmd, bit [ADC_BITS-1:0] raw);
         bit [31:0]        inst;
         bit [31:0]        acc;
         bit [PQ8_W-1:0]   p;
         bit [31:0]        a;
         bit [31:0]        r;
         reading_type      e;
         if (raw == '0) begin
            mv_avg = '0;
         end else begin
            inst = (32'(raw) * 32'(MV_SCALE) + (32'd1 << (ADC_BITS - 1))) >> ADC_BITS;
            if (mv_avg == '0) begin
               mv_avg = inst[MV_W-1:0];
            end else begin
               acc = (32'(MV_EMA_KEEP) * 32'(mv_avg) + inst + 32'(MV_EMA_RND)) >> 4;
               mv_avg = acc[MV_W-1:0];
            end
         end
         e.mv  = mv_avg;
         e.pct = PCT_INVALID;
         if (cmd == CMD_MV_PCT) begin
            if (mv_avg < MV_VALID_MIN) begin
               // invalid reading: drop the percent history
               pct_seeded = 1'b0;
               pct_avg    = '0;
            end else begin
               p = map_pct_q8(mv_avg);
               a = (alpha > ALPHA_ONE) ? 32'(ALPHA_ONE) : 32'(alpha);
               if (!pct_seeded) begin
                  pct_avg    = p;
                  pct_seeded = 1'b1;
               end else begin
                  acc = ((32'(ALPHA_ONE) - a) * 32'(pct_avg) + a * 32'(p)
                         + 32'(PCT_HALF_Q8)) >> 8;
                  pct_avg = acc[PQ8_W-1:0];
               end
               r = (32'(pct_avg) + 32'(PCT_HALF_Q8)) >> 8;
               if (r > 32'(PCT_CAP)) r = 32'(PCT_CAP);
               e.pct = r[PCT_W-1:0];
            end
         end
         due.push_back(e);
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endtask

      task check_result(bit [MV_W-1:0] mv, bit [PCT_W-1:0] pct);
         reading_type e;
         if (due.size() == 0) begin
            report($sformatf("unexpected result beat mv=%0d pct=%0d", mv, $signed(pct)));
         end else begin
            e = due.pop_front();
            if (mv != e.mv)
               report($sformatf("battery_mv got %0d want %0d", mv, e.mv));
            if (pct != e.pct)
               report($sformatf("percent got %0d want %0d", $signed(pct), $signed(e.pct)));
         end
      endtask

      function int pending();
         return due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MV_W-1:0]      csr_wdata;

   bgs_req_if req_ch();
   bgs_rsp_if rsp_ch();

   gauge_scoreboard_type sb = new();
   int  cycles = 0;
   bit  calm = 1'b0;
   int  tx_gap_odds = 0;
   int  rx_odds = 8;
   int  stall_left = 0;

   battery_gauge_smoother u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_battery_gauge_smoother failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.battery_mv, rsp_ch.percent);
   end

   // Result-side stalls in random bursts (none once calm is set), odds re-picked now and then.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 127) == 0)
            case ($urandom_range(0, 2))
               0: rx_odds = 3;
               1: rx_odds = 8;
               default: rx_odds = 1000;
            endcase
         if (stall_left == 0 && !calm && $urandom_range(0, rx_odds) == 0)
            stall_left = $urandom_range(1, 16);
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic push_sample(bit cmd, bit [ADC_BITS-1:0] raw);
      if (!calm && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.adc_sample <= raw;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(cmd, raw);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(bit [CSR_IDX_W-1:0] idx, bit [MV_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(int lo, int hi, int span, int alpha);
      drain_results();
      write_csr(CSR_MV_MIN, MV_W'(lo));
      write_csr(CSR_MV_MAX, MV_W'(hi));
      write_csr(CSR_MV_SPAN, MV_W'(span));
      write_csr(CSR_ALPHA_Q8, MV_W'(alpha));
   endtask

   // Runs of samples jittered around a random level, with some noise beats mixed in.
   task automatic random_phase(int n, int lo_mv, int hi_mv);
      int count;
      int run_len;
      int center;
      int mv;
      int kind;
      bit [ADC_BITS-1:0] raw;
      count = 0;
      if (lo_mv < 0) lo_mv = 0;
      if (hi_mv > 14748) hi_mv = 14748;
      while (count < n) begin
         run_len = $urandom_range(4, 24);
         center  = $urandom_range(lo_mv, hi_mv);
         case ($urandom_range(0, 2))
            0: tx_gap_odds = 0;
            1: tx_gap_odds = 3;
            default: tx_gap_odds = 8;
         endcase
         if ($urandom_range(0, 15) == 0) drain_results();
         for (int i = 0; i < run_len && count < n; i++) begin
            kind = $urandom_range(0, 19);
            mv = center + $urandom_range(0, 300) - 150;
            if (mv < 0) mv = 0;
            if (mv > 14748) mv = 14748;
            raw = ((mv * 4096) / 14748 > 4095) ? 12'hFFF : 12'((mv * 4096) / 14748);
            case (kind)
               0: push_sample(CMD_MV_PCT, '0);
               1: push_sample(CMD_MV_PCT, 12'($urandom_range(0, 4095)));
               2: push_sample(CMD_MV_ONLY, 12'($urandom_range(0, 4095)));
               3: push_sample(CMD_MV_ONLY, raw);
               default: push_sample(CMD_MV_PCT, raw);
            endcase
            count++;
         end
      end
   endtask

   initial begin
      int lo;
      int hi;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = 1'b0;
      req_ch.adc_sample = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero clears, full scale, command 0, tiny sample below 2500 mV, seeding.
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'hFFF);
      push_sample(CMD_MV_ONLY, 12'hFFF);
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'd1);
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'd1051);
      push_sample(CMD_MV_PCT, 12'd1051);
      push_sample(CMD_MV_PCT, 12'd1180);
      push_sample(CMD_MV_ONLY, 12'd2730);
      push_sample(CMD_MV_PCT, 12'd1051);
      push_sample(CMD_MV_PCT, 12'd2730);

      // Directed: mV exactly at min and max, just below and above 2500 mV, alpha full.
      set_config(3302, 4202, 900, ALPHA_ONE);
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'd917);
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'd1167);
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'd694);
      push_sample(CMD_MV_PCT, '0);
      push_sample(CMD_MV_PCT, 12'd695);
      push_sample(CMD_MV_PCT, 12'd1000);

      set_config(MV_MIN_RST, MV_MAX_RST, MV_SPAN_RST, ALPHA_RST);
      random_phase(100, 2300, 4500);

      set_config(0, 14748, 14748, ALPHA_ONE);
      random_phase(50, 1000, 14748);

      // min above max, zero span, zero alpha
      set_config(4000, 3000, 0, 0);
      random_phase(40, 2400, 4600);

      set_config(16383, 16383, 16383, 511);
      random_phase(20, 2000, 14748);

      set_config(3000, 3600, 1, 300);
      random_phase(30, 2400, 4000);

      repeat (3) begin
         lo = $urandom_range(2000, 5000);
         hi = lo + $urandom_range(0, 3000);
         set_config(lo, hi, ($urandom_range(0, 1) == 1) ? ((hi > lo) ? hi - lo : 1)
                                                          : $urandom_range(0, 16383),
                    $urandom_range(0, 511));
         random_phase(30, lo - 400, hi + 400);
      end

      set_config(MV_MIN_RST, MV_MAX_RST, MV_SPAN_RST, ALPHA_RST);
      calm = 1'b1;
      random_phase(60, 2300, 4500);

      drain_results();
      repeat (60) @(negedge clock);
      if (sb.errors == 0)
         $display("tb_battery_gauge_smoother passed");
      else
         $display("tb_battery_gauge_smoother failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/bgs_pkg.sv
design/bgs_req_if.sv
design/bgs_rsp_if.sv
design/bgs_mac.sv
design/bgs_divider.sv
design/battery_gauge_smoother.sv
tb/tb_battery_gauge_smoother.sv
